/* src/wtc_pkg.sv */
// Shared types, constants and keyword tables for the whitespace token classifier.
package wtc_pkg;

   localparam logic [31:0] MAX_TOKEN_LEN = 32'd65535;
   localparam logic [15:0] LEN_CAP =
      (MAX_TOKEN_LEN > 32'd65535) ? 16'hFFFF : MAX_TOKEN_LEN[15:0];

   localparam int KW_COUNT = 9;

   localparam logic [4:0] CLS_EQUAL      = 5'd9;
   localparam logic [4:0] CLS_PLUS       = 5'd10;
   localparam logic [4:0] CLS_MINUS      = 5'd11;
   localparam logic [4:0] CLS_STAR       = 5'd12;
   localparam logic [4:0] CLS_SLASH      = 5'd13;
   localparam logic [4:0] CLS_LPAREN     = 5'd14;
   localparam logic [4:0] CLS_RPAREN     = 5'd15;
   localparam logic [4:0] CLS_LBRACE     = 5'd16;
   localparam logic [4:0] CLS_RBRACE     = 5'd17;
   localparam logic [4:0] CLS_COLON      = 5'd18;
   localparam logic [4:0] CLS_COMMA      = 5'd19;
   localparam logic [4:0] CLS_SEMI       = 5'd20;
   localparam logic [4:0] CLS_GREATER_EQ = 5'd21;
   localparam logic [4:0] CLS_GREATER    = 5'd22;
   localparam logic [4:0] CLS_LESS_EQ    = 5'd23;
   localparam logic [4:0] CLS_LESS       = 5'd24;
   localparam logic [4:0] CLS_NOT_EQ     = 5'd25;
   localparam logic [4:0] CLS_IDENT      = 5'd26;
   localparam logic [4:0] CLS_NUMBER     = 5'd27;
   localparam logic [4:0] CLS_STRING     = 5'd28;
   localparam logic [4:0] CLS_NONE       = 5'd29;

   // Keyword text, right aligned: last character in the low byte.
   localparam logic [KW_COUNT-1:0][71:0] KW_TEXT = {
      72'("telemetry"), 72'("connect"), 72'("sleep"), 72'("print"), 72'("while"),
      72'("else"), 72'("if"), 72'("bind"), 72'("var")
   };
   localparam logic [KW_COUNT-1:0][3:0] KW_LEN = {
      4'd9, 4'd7, 4'd5, 4'd5, 4'd5, 4'd4, 4'd2, 4'd4, 4'd3
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_class;
      logic [31:0] token_start;
      logic [15:0] token_length;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [7:0]          first_char;
      logic [7:0]          second_char;
      logic [7:0]          previous_char;
      logic [15:0]         char_count;
      logic [KW_COUNT-1:0] keyword_alive;
      logic                ident_ok;
      logic                number_ok;
   } tok_state_type;

   function automatic logic [7:0] kw_char(logic [3:0] k, logic [3:0] pos);
      logic [3:0] idx;
      idx = KW_LEN[k] - 4'd1 - pos;
      return KW_TEXT[k][{idx, 3'b000} +: 8];
   endfunction

endpackage

/* src/whitespace_token_classifier.sv */
// Top level: byte input register, token state update and result register.
// Order: input register, then result register driving rsp_valid.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or being drained in the same cycle.
// Reset clears the token state, the byte offset and both valid flags.
module whitespace_token_classifier
   import wtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic          in_valid_ff;
   req_type       in_ff;
   tok_state_type tok_ff, tok_in, tok_upd;
   logic          inside_ff, inside_in, inside_upd;
   logic          point_ff, point_in, point_upd;
   logic [31:0]   start_ff, start_in, start_upd;
   logic [31:0]   pos_ff, pos_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_load;
   logic          advance;
   logic [4:0]    cls;
   logic [7:0]    c;
   logic          e, is_sep, is_alpha, is_digit;

   wtc_classify u_classify (
      .tok         (tok_upd),
      .token_class (cls)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      c          = in_ff.data_byte;
      e          = in_ff.end_of_text;
      is_sep     = c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
      is_alpha   = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
      is_digit   = c >= 8'h30 && c <= 8'h39;
      tok_upd    = tok_ff;
      inside_upd = inside_ff;
      point_upd  = point_ff;
      start_upd  = start_ff;
      if (!is_sep) begin
         if (!inside_ff) begin
            inside_upd            = 1'b1;
            start_upd             = pos_ff;
            tok_upd.char_count    = '0;
            tok_upd.keyword_alive = '1;
            tok_upd.first_char    = c;
            tok_upd.second_char   = '0;
            tok_upd.ident_ok      = is_alpha || c == 8'h5F;
            tok_upd.number_ok     = 1'b1;
            point_upd             = 1'b0;
         end else if (!(is_alpha || is_digit || c == 8'h5F)) begin
            tok_upd.ident_ok = 1'b0;
         end
         for (int k = 0; k < KW_COUNT; k++) begin
            if (tok_upd.char_count >= 16'(KW_LEN[k]) ||
                kw_char(4'(k), tok_upd.char_count[3:0]) != c) begin
               tok_upd.keyword_alive[k] = 1'b0;
            end
         end
         if (!is_digit) begin
            if (c == 8'h2E && !point_upd) begin
               point_upd = 1'b1;
            end else begin
               tok_upd.number_ok = 1'b0;
            end
         end
         if (tok_upd.char_count == 16'd1) begin
            tok_upd.second_char = c;
         end
         tok_upd.previous_char = c;
         if (tok_upd.char_count < LEN_CAP) begin
            tok_upd.char_count = tok_upd.char_count + 16'd1;
         end
      end

      rsp_load  = 1'b0;
      rsp_in    = '{CLS_NONE, 32'd0, 16'd0, 1'b1};
      inside_in = inside_upd;
      if (inside_upd && (is_sep || e)) begin
         rsp_load  = 1'b1;
         rsp_in    = '{cls, start_upd, tok_upd.char_count, e};
         inside_in = 1'b0;
      end else if (e) begin
         rsp_load = 1'b1;
      end

      tok_in   = tok_upd;
      point_in = point_upd;
      start_in = start_upd;
      pos_in   = pos_ff;
      if (e) begin
         tok_in    = '0;
         inside_in = 1'b0;
         point_in  = 1'b0;
         start_in  = '0;
         pos_in    = '0;
      end else if (pos_ff != 32'hFFFF_FFFF) begin
         pos_in = pos_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tok_ff       <= '0;
         inside_ff    <= 1'b0;
         point_ff     <= 1'b0;
         start_ff     <= '0;
         pos_ff       <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            tok_ff    <= tok_in;
            inside_ff <= inside_in;
            point_ff  <= point_in;
            start_ff  <= start_in;
            pos_ff    <= pos_in;
         end
         if (advance && rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_ff <= req_data;
      end
      if (advance && rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* src/wtc_classify.sv */
// Token class decision from the running per-token flags.
module wtc_classify
   import wtc_pkg::*;
(
   input  tok_state_type tok,
   output logic [4:0]    token_class
);

   logic kw_hit;
   logic two_eq;

   always_comb begin
      kw_hit      = 1'b0;
      token_class = CLS_IDENT;
      two_eq      = (tok.char_count == 16'd2) && (tok.second_char == 8'h3D);
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (tok.keyword_alive[k] && tok.char_count == 16'(KW_LEN[k])) begin
            kw_hit      = 1'b1;
            token_class = 5'(k);
         end
      end
      if (!kw_hit) begin
         case (tok.first_char)
            8'h3D: token_class = CLS_EQUAL;
            8'h2B: token_class = CLS_PLUS;
            8'h2D: token_class = CLS_MINUS;
            8'h2A: token_class = CLS_STAR;
            8'h2F: token_class = CLS_SLASH;
            8'h28: token_class = CLS_LPAREN;
            8'h29: token_class = CLS_RPAREN;
            8'h7B: token_class = CLS_LBRACE;
            8'h7D: token_class = CLS_RBRACE;
            8'h3A: token_class = CLS_COLON;
            8'h2C: token_class = CLS_COMMA;
            8'h3B: token_class = CLS_SEMI;
            8'h3E: token_class = two_eq ? CLS_GREATER_EQ : CLS_GREATER;
            8'h3C: token_class = two_eq ? CLS_LESS_EQ : CLS_LESS;
            default: begin
               if (tok.first_char == 8'h21 && two_eq) begin
                  token_class = CLS_NOT_EQ;
               end else if (tok.ident_ok) begin
                  token_class = CLS_IDENT;
               end else if (tok.number_ok) begin
                  token_class = CLS_NUMBER;
               end else if (tok.char_count >= 16'd2 &&
                            ((tok.first_char == 8'h22 && tok.previous_char == 8'h22) ||
                             (tok.first_char == 8'h27 && tok.previous_char == 8'h27))) begin
                  token_class = CLS_STRING;
               end else begin
                  token_class = CLS_IDENT;
               end
            end
         endcase
      end
   end

endmodule

/* tb/sv/token_stream_checker.sv */
// Checker for the token classifier: predicts each token from the byte stream and compares results.
`timescale 1ns / 100ps

module token_stream_checker
   import wtc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int          mismatches,
   output int          tokens_checked,
   output int          tokens_pending,
   output logic [29:0] classes_seen
);

   bit          in_token;
   logic [7:0]  first_ch;
   logic [7:0]  second_ch;
   logic [7:0]  prev_ch;
   logic [15:0] tok_len;
   logic [31:0] tok_start;
   logic [31:0] offset;
   logic [8:0]  kw_live;
   bit          ident_like;
   bit          number_like;
   bit          point_found;

   rsp_type     due_tokens[$];
   int          fail_n = 0;
   int          ok_n = 0;
   logic [29:0] seen = '0;

   function automatic string kw_word(int k);
      case (k)
         0: return "var";
         1: return "bind";
         2: return "if";
         3: return "else";
         4: return "while";
         5: return "print";
         6: return "sleep";
         7: return "connect";
         default: return "telemetry";
      endcase
   endfunction

   function automatic bit is_sep(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task clear_token_state();
      in_token = 0;
      first_ch = '0;
      second_ch = '0;
      prev_ch = '0;
      tok_len = '0;
      tok_start = '0;
      offset = '0;
      kw_live = '0;
      ident_like = 0;
      number_like = 0;
      point_found = 0;
   endtask

   function automatic logic [4:0] classify_token();
      string w;
      for (int k = 0; k < 9; k++) begin
         w = kw_word(k);
         if (kw_live[k] && tok_len == w.len())
            return 5'(k);
      end
      case (first_ch)
         "=": return CLS_EQUAL;
         "+": return CLS_PLUS;
         "-": return CLS_MINUS;
         "*": return CLS_STAR;
         "/": return CLS_SLASH;
         "(": return CLS_LPAREN;
         ")": return CLS_RPAREN;
         "{": return CLS_LBRACE;
         "}": return CLS_RBRACE;
         ":": return CLS_COLON;
         ",": return CLS_COMMA;
         ";": return CLS_SEMI;
         ">": return (tok_len == 2 && second_ch == "=") ? CLS_GREATER_EQ : CLS_GREATER;
         "<": return (tok_len == 2 && second_ch == "=") ? CLS_LESS_EQ : CLS_LESS;
         "!": begin
            if (tok_len == 2 && second_ch == "=")
               return CLS_NOT_EQ;
         end
         default: ;
      endcase
      if (ident_like)
         return CLS_IDENT;
      if (number_like)
         return CLS_NUMBER;
      if (tok_len >= 2 && ((first_ch == "\"" && prev_ch == "\"") ||
                           (first_ch == "'" && prev_ch == "'")))
         return CLS_STRING;
      return CLS_IDENT;
   endfunction

   task scan_byte(input req_type r, output bit emits, output rsp_type tok);
      logic [7:0] c;
      string      w;
      c = r.data_byte;
      emits = 0;
      tok = '0;
      if (!is_sep(c)) begin
         if (!in_token) begin
            in_token = 1;
            tok_start = offset;
            tok_len = '0;
            kw_live = '1;
            first_ch = c;
            second_ch = '0;
            ident_like = is_alpha(c) || c == "_";
            number_like = 1;
            point_found = 0;
         end else if (!(is_alpha(c) || is_digit(c) || c == "_")) begin
            ident_like = 0;
         end
         for (int k = 0; k < 9; k++) begin
            w = kw_word(k);
            if (tok_len >= w.len())
               kw_live[k] = 1'b0;
            else if (w[tok_len] != c)
               kw_live[k] = 1'b0;
         end
         if (!is_digit(c)) begin
            if (c == "." && !point_found)
               point_found = 1;
            else
               number_like = 0;
         end
         if (tok_len == 16'd1)
            second_ch = c;
         prev_ch = c;
         if (tok_len < LEN_CAP)
            tok_len = tok_len + 16'd1;
      end
      if (in_token && (is_sep(c) || r.end_of_text)) begin
         tok.token_class = classify_token();
         tok.token_start = tok_start;
         tok.token_length = tok_len;
         tok.last_result = r.end_of_text;
         in_token = 0;
         emits = 1;
      end else if (r.end_of_text) begin
         tok.token_class = CLS_NONE;
         tok.last_result = 1'b1;
         emits = 1;
      end
      if (r.end_of_text)
         clear_token_state();
      else if (offset != 32'hFFFF_FFFF)
         offset = offset + 32'd1;
   endtask

   always @(posedge clock) begin : monitor
      bit      emits;
      rsp_type tok;
      rsp_type want;
      if (reset) begin
         clear_token_state();
         due_tokens.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            ok_n++;
            if (rsp_data.token_class < 5'd30)
               seen[rsp_data.token_class] = 1'b1;
            if (due_tokens.size() == 0) begin
               fail_n++;
               if (fail_n <= 10)
                  $display("%0t: unexpected token class=%0d start=%0d len=%0d last=%0b",
                           $realtime, rsp_data.token_class, rsp_data.token_start,
                           rsp_data.token_length, rsp_data.last_result);
            end else begin
               want = due_tokens.pop_front();
               if (rsp_data.token_class !== want.token_class ||
                   rsp_data.token_start !== want.token_start ||
                   rsp_data.token_length !== want.token_length ||
                   rsp_data.last_result !== want.last_result) begin
                  fail_n++;
                  if (fail_n <= 10) begin
                     $write("%0t: token differs: class exp %0d got %0d, start exp %0d got %0d,",
                            $realtime, want.token_class, rsp_data.token_class,
                            want.token_start, rsp_data.token_start);
                     $display(" len exp %0d got %0d, last exp %0b got %0b",
                              want.token_length, rsp_data.token_length,
                              want.last_result, rsp_data.last_result);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            scan_byte(req_data, emits, tok);
            if (emits)
               due_tokens = {due_tokens, tok};
         end
      end
      mismatches <= fail_n;
      tokens_checked <= ok_n;
      tokens_pending <= due_tokens.size();
      classes_seen <= seen;
   end

endmodule

/* tb/sv/whitespace_token_classifier_tb.sv */
// Testbench top for the token classifier: drives byte streams, handles handshakes, reports the verdict.
`timescale 1ns / 100ps

module whitespace_token_classifier_tb;
   import wtc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;

   int          mismatches;
   int          tokens_checked;
   int          tokens_pending;
   logic [29:0] classes_seen;

   bit          quiet = 0;
   int          bytes_sent = 0;
   int          stall_cycles = 0;

   whitespace_token_classifier uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   token_stream_checker token_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatches     (mismatches),
      .tokens_checked (tokens_checked),
      .tokens_pending (tokens_pending),
      .classes_seen   (classes_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 32);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= 2000) begin
         $display("whitespace_token_classifier: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic string keyword_at(int k);
      case (k)
         0: return "var";
         1: return "bind";
         2: return "if";
         3: return "else";
         4: return "while";
         5: return "print";
         6: return "sleep";
         7: return "connect";
         default: return "telemetry";
      endcase
   endfunction

   function automatic logic [7:0] sep_char();
      case ($urandom_range(0, 3))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0D;
         default: return 8'h0A;
      endcase
   endfunction

   function automatic logic [7:0] word_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range("a", "z"));
         1: return 8'($urandom_range("A", "Z"));
         2: return 8'($urandom_range("0", "9"));
         default: return "_";
      endcase
   endfunction

   function automatic logic [7:0] token_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task send_byte(input logic [7:0] c, input bit last);
      req_type item;
      if (!quiet && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      item.data_byte = c;
      item.end_of_text = last;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task send_text(input string s, input bit end_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], end_last && i == s.len() - 1);
   endtask

   task send_random_token();
      logic [7:0] tok[$];
      string      w;
      string      syms;
      logic [7:0] q;
      int         n;
      int         end_mode;
      syms = "=+-*/(){}:,;><!";
      case ($urandom_range(0, 9))
         0, 1: begin
            w = keyword_at($urandom_range(0, 8));
            for (int i = 0; i < w.len(); i++) tok = {tok, w[i]};
         end
         2: begin
            w = keyword_at($urandom_range(0, 8));
            for (int i = 0; i < w.len(); i++) tok = {tok, w[i]};
            case ($urandom_range(0, 2))
               0: void'(tok.pop_back());
               1: tok = {tok, word_char()};
               default: tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range("a", "z"));
            endcase
         end
         3: tok = {tok, syms[$urandom_range(0, syms.len() - 1)]};
         4: begin
            tok = {tok, syms[$urandom_range(0, syms.len() - 1)]};
            tok = {tok, (($urandom_range(0, 2) != 0) ? 8'("=") : token_char())};
            if ($urandom_range(0, 3) == 0) tok = {tok, token_char()};
         end
         5: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               tok = {tok, (($urandom_range(0, 4) == 0) ? 8'(".") : 8'($urandom_range("0", "9")))};
         end
         6: begin
            q = ($urandom_range(0, 1) != 0) ? 8'("\"") : 8'("'");
            tok = {tok, q};
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) tok = {tok, 8'($urandom_range(33, 126))};
            case ($urandom_range(0, 4))
               0: ;
               1: tok = {tok, ((q == "'") ? 8'("\"") : 8'("'"))};
               default: tok = {tok, q};
            endcase
         end
         7: begin
            tok = {tok, (($urandom_range(0, 3) == 0) ? 8'("_") : 8'($urandom_range("a", "z")))};
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) tok = {tok, word_char()};
            if ($urandom_range(0, 3) == 0) tok = {tok, syms[$urandom_range(0, syms.len() - 1)]};
         end
         8: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) tok = {tok, token_char()};
         end
         default: ;
      endcase
      end_mode = $urandom_range(0, 29);
      for (int i = 0; i < tok.size(); i++)
         send_byte(tok[i], end_mode == 0 && i == tok.size() - 1);
      n = $urandom_range(1, 2);
      for (int j = 0; j < n; j++)
         send_byte(sep_char(), end_mode == 1 && j == n - 1);
      if (end_mode == 2)
         send_byte(sep_char(), 1'b1);
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h20, 1'b1);
      send_text("x", 1'b1);
      send_text("! != >= . '' 1.2 else", 1'b1);

      send_byte(sep_char(), 1'b0);
      send_text("z", 1'b1);

      bytes_sent = 0;
      while (bytes_sent < 850) begin
         quiet = bytes_sent >= 300 && bytes_sent < 500;
         send_random_token();
      end
      quiet = 0;
      req_valid <= 1'b0;

      do @(posedge clock); while (tokens_pending != 0);
      repeat (8) @(posedge clock);

      $display("random phase: %0d bytes; %0d tokens checked, %0d of 30 classes seen",
               bytes_sent, tokens_checked, $countones(classes_seen));
      $display("directed phase covered empty and token-byte end, lone point and bang");
      if (mismatches == 0)
         $display("whitespace_token_classifier: match");
      else
         $display("whitespace_token_classifier: mismatch");
      $finish;
   end

endmodule
